@@ sv/tlt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types, token codes and keyword table of the tiny language tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

   localparam int KEYWORD_CHARS_DEF = 6;
   localparam int LINE_BITS_DEF     = 16;
   localparam int LINE_OUT_BITS     = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int KEYWORD_COUNT     = 8;
   localparam int KEYWORD_BITS      = 48;

   // token kinds
   localparam logic [2:0] KIND_IDENT       = 3'd0;
   localparam logic [2:0] KIND_NUMBER      = 3'd1;
   localparam logic [2:0] KIND_KEYWORD     = 3'd2;
   localparam logic [2:0] KIND_OPER        = 3'd3;
   localparam logic [2:0] KIND_END_OF_FILE = 3'd4;
   localparam logic [2:0] KIND_ERROR       = 3'd5;

   // operator codes
   localparam logic [3:0] OP_ASSIGN = 4'd0;
   localparam logic [3:0] OP_EQ     = 4'd1;
   localparam logic [3:0] OP_LT     = 4'd2;
   localparam logic [3:0] OP_LE     = 4'd3;
   localparam logic [3:0] OP_GT     = 4'd4;
   localparam logic [3:0] OP_GE     = 4'd5;
   localparam logic [3:0] OP_PLUS   = 4'd6;
   localparam logic [3:0] OP_MINUS  = 4'd7;
   localparam logic [3:0] OP_TIMES  = 4'd8;
   localparam logic [3:0] OP_OVER   = 4'd9;
   localparam logic [3:0] OP_LPAREN = 4'd10;
   localparam logic [3:0] OP_RPAREN = 4'd11;
   localparam logic [3:0] OP_SEMI   = 4'd12;

   // characters
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;

   localparam logic [30:0] NUMBER_MAX = 31'h7FFF_FFFF;
   localparam logic [7:0]  RUN_MAX    = 8'hFF;

   // keywords, first character in the low byte
   localparam logic [KEYWORD_BITS-1:0] KEYWORD_TEXT [KEYWORD_COUNT] = '{
      48'h0000_0000_6669,   // if
      48'h0000_6E65_6874,   // then
      48'h0000_6573_6C65,   // else
      48'h0000_0064_6E65,   // end
      48'h7461_6570_6572,   // repeat
      48'h006C_6974_6E75,   // until
      48'h0000_6461_6572,   // read
      48'h0065_7469_7277    // write
   };
   localparam logic [7:0] KEYWORD_LENGTH [KEYWORD_COUNT] = '{
      8'd2, 8'd4, 8'd4, 8'd3, 8'd6, 8'd5, 8'd4, 8'd5
   };

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  code;
      logic [30:0] value;
      logic [7:0]  length;
      logic [15:0] line;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  slot0;
      token_type  slot1;
   } push_type;

   typedef struct packed {
      logic [QUEUE_LEVEL_BITS-1:0] level;
      logic                        has_room;
      logic                        not_empty;
   } queue_status_type;

   function automatic token_type make_token(input logic [2:0] kind, input logic [3:0] code,
                                            input logic [30:0] value, input logic [7:0] len,
                                            input logic [15:0] line);
      token_type tok;
      tok.kind   = kind;
      tok.code   = code;
      tok.value  = value;
      tok.length = len;
      tok.line   = line;
      tok.last   = 1'b0;
      return tok;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_op_start(input logic [7:0] c);
      return c == CH_COLON || c == CH_GT || c == CH_LT || c == CH_EQUAL || c == CH_PLUS ||
             c == CH_MINUS || c == CH_SEMI || c == CH_SLASH || c == CH_STAR;
   endfunction

   // {known, code} of a one-character operator
   function automatic logic [4:0] single_op(input logic [7:0] c);
      logic [4:0] res;
      unique case (c)
         CH_EQUAL: res = {1'b1, OP_EQ};
         CH_LT:    res = {1'b1, OP_LT};
         CH_GT:    res = {1'b1, OP_GT};
         CH_PLUS:  res = {1'b1, OP_PLUS};
         CH_MINUS: res = {1'b1, OP_MINUS};
         CH_STAR:  res = {1'b1, OP_TIMES};
         CH_SLASH: res = {1'b1, OP_OVER};
         CH_SEMI:  res = {1'b1, OP_SEMI};
         default:  res = {1'b0, OP_ASSIGN};
      endcase
      return res;
   endfunction

   // {hit, index} of a keyword match
   function automatic logic [3:0] keyword_lookup(input logic [KEYWORD_BITS-1:0] text,
                                                 input logic [7:0] len);
      logic [3:0] res;
      res = 4'd0;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (len == KEYWORD_LENGTH[k] && text == KEYWORD_TEXT[k]) begin
            res = {1'b1, 3'(k)};
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ sv/tlt_if.sv @@
// ----------------------------------------------------------------------------
// tlt_if
// Valid/ready channels of the tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface tlt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [3:0]  token_code;
   logic [30:0] number_value;
   logic [7:0]  text_length;
   logic [15:0] line_number;
   logic        last_result;

   modport source (output valid, output token_kind, output token_code, output number_value,
                   output text_length, output line_number, output last_result, input ready);
   modport sink   (input valid, input token_kind, input token_code, input number_value,
                   input text_length, input line_number, input last_result, output ready);
endinterface

`default_nettype wire

@@ sv/tiny_language_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tiny_language_tokenizer: source bytes in, tokens out, one byte per cycle while the token queue has room.
// A token is written into the token queue when its byte is accepted and is offered on rsp from the queue head.
// A byte giving two tokens needs two rsp transfers; a 4-entry queue absorbs them.
// Synchronous reset: start state, line count 1, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_language_tokenizer #(
   parameter int KEYWORD_CHARS = tlt_pkg::KEYWORD_CHARS_DEF,
   parameter int LINE_BITS     = tlt_pkg::LINE_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   tlt_req_if.sink     req_chan,
   tlt_rsp_if.source   rsp_chan
);

   logic                       req_accept;
   logic                       rsp_accept;
   tlt_pkg::push_type          push;
   tlt_pkg::token_type         head;
   tlt_pkg::queue_status_type  status;

   assign req_chan.ready = status.has_room;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_accept     = rsp_chan.valid && rsp_chan.ready;

   tlt_scanner #(
      .KEYWORD_CHARS (KEYWORD_CHARS),
      .LINE_BITS     (LINE_BITS)
   ) u_scanner (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .char_code    (req_chan.char_code),
      .end_of_input (req_chan.end_of_input),
      .push         (push)
   );

   tlt_token_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_accept),
      .head   (head),
      .status (status)
   );

   assign rsp_chan.valid        = status.not_empty;
   assign rsp_chan.token_kind   = head.kind;
   assign rsp_chan.token_code   = head.code;
   assign rsp_chan.number_value = head.value;
   assign rsp_chan.text_length  = head.length;
   assign rsp_chan.line_number  = head.line;
   assign rsp_chan.last_result  = head.last;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      status.level <= tlt_pkg::QUEUE_LEVEL_BITS'(tlt_pkg::QUEUE_DEPTH))
      else $error("token queue overflow");

   a_end_gives_token: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.end_of_input |=> rsp_chan.valid)
      else $error("end of input produced no token");

   a_single_pop: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ({1'b0, status.level} + 1'b1) >= {1'b0, $past(status.level)})
      else $error("token queue dropped more than one entry");
`endif

endmodule

`default_nettype wire

@@ sv/tlt_scanner.sv @@
// ----------------------------------------------------------------------------
// tlt_scanner
// Scanner state and token generation: one source byte per transaction,
// zero to two tokens pushed per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_scanner #(
   parameter int KEYWORD_CHARS = tlt_pkg::KEYWORD_CHARS_DEF,
   parameter int LINE_BITS     = tlt_pkg::LINE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        char_code,
   input  wire logic              end_of_input,
   output tlt_pkg::push_type      push
);

   typedef enum logic [2:0] {
      MODE_START,
      MODE_NAME,
      MODE_NUMBER,
      MODE_OPER,
      MODE_COMMENT
   } mode_type;

   localparam int NAME_BITS = 8 * KEYWORD_CHARS;

   mode_type               mode_ff, mode_in;
   logic [NAME_BITS-1:0]   name_ff, name_in;
   logic [7:0]             run_ff, run_in;
   logic [30:0]            acc_ff, acc_in;
   logic [7:0]             first_ff, first_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;

   logic [15:0]            line_out;
   logic [LINE_BITS-1:0]   line_next;
   logic [7:0]             run_next;
   logic [34:0]            acc_sum;
   logic [30:0]            acc_next;
   logic [NAME_BITS-1:0]   name_next;
   logic [3:0]             kw;
   logic [4:0]             op_single;

   logic                   close_valid;
   tlt_pkg::token_type     close_tok;
   tlt_pkg::token_type     pair_tok;
   tlt_pkg::token_type     end_tok;

   mode_type               st_mode;
   logic [NAME_BITS-1:0]   st_name;
   logic [7:0]             st_run;
   logic [30:0]            st_acc;
   logic [7:0]             st_first;
   logic                   st_tok_valid;
   tlt_pkg::token_type     st_tok;

   logic                   do_start;
   logic                   f_valid, s_valid;
   tlt_pkg::token_type     f_tok, s_tok;

   generate
      if (LINE_BITS > tlt_pkg::LINE_OUT_BITS) begin : g_line_sat
         assign line_out = (line_ff[LINE_BITS-1:tlt_pkg::LINE_OUT_BITS] != '0)
                           ? '1 : line_ff[tlt_pkg::LINE_OUT_BITS-1:0];
      end else begin : g_line_ext
         assign line_out = 16'(line_ff);
      end
   endgenerate

   assign line_next = (line_ff != '1) ? line_ff + LINE_BITS'(1) : line_ff;
   assign run_next  = (run_ff != tlt_pkg::RUN_MAX) ? run_ff + 8'd1 : run_ff;

   // acc * 10 + digit
   assign acc_sum  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {31'd0, char_code[3:0]};
   assign acc_next = (acc_sum[34:31] != 4'd0) ? tlt_pkg::NUMBER_MAX : acc_sum[30:0];

   always_comb begin
      name_next = name_ff;
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
         if (run_ff == 8'(i)) begin
            name_next[8*i +: 8] = char_code;
         end
      end
   end

   assign kw        = tlt_pkg::keyword_lookup(name_ff[tlt_pkg::KEYWORD_BITS-1:0], run_ff);
   assign op_single = tlt_pkg::single_op(first_ff);

   // token that closes the open name, number or operator
   always_comb begin
      close_valid = 1'b0;
      close_tok   = tlt_pkg::make_token(tlt_pkg::KIND_IDENT, 4'd0, 31'd0, run_ff, line_out);
      unique case (mode_ff)
         MODE_NAME: begin
            close_valid = 1'b1;
            if (kw[3]) begin
               close_tok = tlt_pkg::make_token(tlt_pkg::KIND_KEYWORD, {1'b0, kw[2:0]}, 31'd0,
                                               run_ff, line_out);
            end
         end
         MODE_NUMBER: begin
            close_valid = 1'b1;
            close_tok   = tlt_pkg::make_token(tlt_pkg::KIND_NUMBER, 4'd0, acc_ff, run_ff,
                                              line_out);
         end
         MODE_OPER: begin
            close_valid = 1'b1;
            if (op_single[4]) begin
               close_tok = tlt_pkg::make_token(tlt_pkg::KIND_OPER, op_single[3:0], 31'd0,
                                               8'd1, line_out);
            end else begin
               close_tok = tlt_pkg::make_token(tlt_pkg::KIND_ERROR, 4'd0, 31'd0, 8'd1,
                                               line_out);
            end
         end
         default: begin
            close_valid = 1'b0;
         end
      endcase
   end

   // two-character operator
   always_comb begin
      priority if (first_ff == tlt_pkg::CH_COLON) begin
         pair_tok = tlt_pkg::make_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_ASSIGN, 31'd0, 8'd2,
                                        line_out);
      end else if (first_ff == tlt_pkg::CH_LT) begin
         pair_tok = tlt_pkg::make_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_LE, 31'd0, 8'd2,
                                        line_out);
      end else if (first_ff == tlt_pkg::CH_GT) begin
         pair_tok = tlt_pkg::make_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_GE, 31'd0, 8'd2,
                                        line_out);
      end else begin
         pair_tok = tlt_pkg::make_token(tlt_pkg::KIND_ERROR, 4'd0, 31'd0, 8'd2, line_out);
      end
   end

   assign end_tok = tlt_pkg::make_token(tlt_pkg::KIND_END_OF_FILE, 4'd0, 31'd0, 8'd0,
                                        line_out);

   // byte seen from the start state, with a cleared token
   always_comb begin
      st_mode      = MODE_START;
      st_name      = '0;
      st_run       = 8'd0;
      st_acc       = 31'd0;
      st_first     = 8'd0;
      st_tok_valid = 1'b0;
      st_tok       = tlt_pkg::make_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_LPAREN, 31'd0, 8'd1,
                                         line_out);
      priority if (tlt_pkg::is_digit(char_code)) begin
         st_mode = MODE_NUMBER;
         st_run  = 8'd1;
         st_acc  = {27'd0, char_code[3:0]};
      end else if (tlt_pkg::is_alpha(char_code)) begin
         st_mode       = MODE_NAME;
         st_run        = 8'd1;
         st_name[7:0]  = char_code;
      end else if (char_code == tlt_pkg::CH_LBRACE) begin
         st_mode = MODE_COMMENT;
      end else if (tlt_pkg::is_op_start(char_code)) begin
         st_mode  = MODE_OPER;
         st_first = char_code;
         st_run   = 8'd1;
      end else if (char_code == tlt_pkg::CH_LPAREN) begin
         st_tok_valid = 1'b1;
      end else if (char_code == tlt_pkg::CH_RPAREN) begin
         st_tok_valid = 1'b1;
         st_tok.code  = tlt_pkg::OP_RPAREN;
      end else begin
         st_mode = MODE_START;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      name_in  = name_ff;
      run_in   = run_ff;
      acc_in   = acc_ff;
      first_in = first_ff;
      line_in  = line_ff;
      do_start = 1'b0;
      f_valid  = 1'b0;
      f_tok    = close_tok;
      s_valid  = 1'b0;
      s_tok    = st_tok;

      if (end_of_input) begin
         f_valid  = close_valid;
         s_valid  = 1'b1;
         s_tok    = end_tok;
         mode_in  = MODE_START;
         name_in  = '0;
         run_in   = 8'd0;
         acc_in   = 31'd0;
         first_in = 8'd0;
         line_in  = LINE_BITS'(1);
      end else begin
         unique case (mode_ff)
            MODE_NAME: begin
               if (tlt_pkg::is_alpha(char_code)) begin
                  name_in = name_next;
                  run_in  = run_next;
               end else begin
                  do_start = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (tlt_pkg::is_digit(char_code)) begin
                  acc_in = acc_next;
                  run_in = run_next;
               end else begin
                  do_start = 1'b1;
               end
            end
            MODE_OPER: begin
               if (char_code == tlt_pkg::CH_EQUAL) begin
                  s_valid  = 1'b1;
                  s_tok    = pair_tok;
                  mode_in  = MODE_START;
                  name_in  = '0;
                  run_in   = 8'd0;
                  acc_in   = 31'd0;
                  first_in = 8'd0;
               end else begin
                  do_start = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (char_code == tlt_pkg::CH_RBRACE) begin
                  mode_in = MODE_START;
               end else if (char_code == tlt_pkg::CH_NEWLINE) begin
                  line_in = line_next;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         if (do_start) begin
            f_valid  = close_valid;
            s_valid  = st_tok_valid;
            mode_in  = st_mode;
            name_in  = st_name;
            run_in   = st_run;
            acc_in   = st_acc;
            first_in = st_first;
            if (char_code == tlt_pkg::CH_NEWLINE) begin
               line_in = line_next;
            end
         end
      end
   end

   // pack tokens in order and mark the last one
   always_comb begin
      push.count = accept ? ({1'b0, f_valid} + {1'b0, s_valid}) : 2'd0;
      push.slot0 = f_valid ? f_tok : s_tok;
      push.slot1 = s_tok;
      push.slot0.last = !(f_valid && s_valid);
      push.slot1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         name_ff  <= '0;
         run_ff   <= 8'd0;
         acc_ff   <= 31'd0;
         first_ff <= 8'd0;
         line_ff  <= LINE_BITS'(1);
      end else if (accept) begin
         mode_ff  <= mode_in;
         name_ff  <= name_in;
         run_ff   <= run_in;
         acc_ff   <= acc_in;
         first_ff <= first_in;
         line_ff  <= line_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/tlt_token_queue.sv @@
// ----------------------------------------------------------------------------
// tlt_token_queue
// Small token queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_token_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tlt_pkg::push_type     push,
   input  wire logic                  pop,
   output tlt_pkg::token_type         head,
   output tlt_pkg::queue_status_type  status
);

   localparam int DEPTH = tlt_pkg::QUEUE_DEPTH;
   localparam int PW    = tlt_pkg::QUEUE_PTR_BITS;
   localparam int LW    = tlt_pkg::QUEUE_LEVEL_BITS;

   tlt_pkg::token_type entry_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]      level_ff, level_in;

   // depth is a power of two, pointers wrap on their own
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign level_in  = level_ff + LW'(push.count) - LW'(pop);

   assign head             = entry_ff[rd_ptr_ff];
   assign status.level     = level_ff;
   assign status.has_room  = level_ff <= LW'(DEPTH - 2);
   assign status.not_empty = level_ff != '0;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PW'(1)] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

@@ dv/tiny_language_tokenizer_test.sv @@
// ----------------------------------------------------------------------------
// tiny_language_tokenizer_test
// Self-checking bench for the tokenizer. Source bytes are queued and sent by a
// driver. Each accepted byte updates a scanner model, which queues the tokens
// it should produce. A monitor checks every returned token, field by field,
// against the oldest queued one. Sender idling and receiver stalling change
// from phase to phase. One phase holds off the receiver for a long stretch,
// and the sender sometimes waits for all outstanding tokens. One source counts
// lines across plain text and a comment.
// ----------------------------------------------------------------------------
module tiny_language_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         QUIET_LIMIT  = 3000;
   localparam int         LONG_HOLD    = 300;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         PRINT_LIMIT  = 40;
   localparam int         RANDOM_CHARS = 370;
   localparam logic [3:0] NO_CODE      = 4'd0;
   localparam logic [15:0] LINE_TOP    = 16'hFFFF;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_HIGH      = 8'hFF;

   typedef enum logic [2:0] {
      SCAN_START, SCAN_NAME, SCAN_NUM, SCAN_OPER, SCAN_COMMENT
   } scan_state_type;

   typedef enum int {
      PH_RESET, PH_DIRECTED, PH_LINES, PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH
   } run_phase_type;

   typedef struct {
      logic [7:0] ch;
      logic       eoi;
      logic       wait_idle;
   } source_char_type;

   string kw_names [8] = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};
   string op_texts [20] = '{":=", "=", "<", "<=", ">", ">=", "+", "-", "*", "/", "(", ")",
                            ";", ":", "+=", "-=", "*=", "/=", ";=", "=="};
   string big_numbers [5] = '{"2147483647", "2147483648", "99999999999", "0", "007"};

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlt_req_if req_chan ();
   tlt_rsp_if rsp_chan ();

   tiny_language_tokenizer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   source_char_type     source_chars [$];
   tlt_pkg::token_type  expected_tokens [$];
   source_char_type     in_flight;
   logic                mark_pause = 1'b0;

   run_phase_type run_phase = PH_RESET;
   run_phase_type rx_phase  = PH_RESET;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int error_count    = 0;
   int token_index    = 0;
   int quiet_cycles   = 0;

   // scanner model state
   scan_state_type sc_mode;
   logic [47:0]    sc_name;
   logic [7:0]     sc_len;
   logic [30:0]    sc_acc;
   logic [7:0]     sc_op;
   logic [15:0]    sc_line;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void clear_run();
      sc_mode = SCAN_START;
      sc_name = '0;
      sc_len  = '0;
      sc_acc  = '0;
      sc_op   = '0;
   endfunction

   function automatic void scanner_reset();
      clear_run();
      sc_line = 16'd1;
   endfunction

   function automatic void push_token(input logic [2:0] kind, input logic [3:0] code,
                                      input logic [30:0] value, input logic [7:0] len);
      tlt_pkg::token_type t;
      t        = '0;
      t.kind   = kind;
      t.code   = code;
      t.value  = value;
      t.length = len;
      t.line   = sc_line;
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   function automatic int find_keyword();
      int   hit;
      logic same;
      hit = -1;
      for (int k = 0; k < tlt_pkg::KEYWORD_COUNT; k++) begin
         if (kw_names[k].len() == sc_len && sc_len <= tlt_pkg::KEYWORD_CHARS_DEF) begin
            same = 1'b1;
            for (int i = 0; i < kw_names[k].len(); i++) begin
               if (kw_names[k][i] != sc_name[8*i +: 8]) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               hit = k;
            end
         end
      end
      return hit;
   endfunction

   function automatic void bump_line();
      if (sc_line != LINE_TOP) begin
         sc_line = sc_line + 16'd1;
      end
   endfunction

   function automatic void add_letter(input logic [7:0] c);
      if (sc_len < tlt_pkg::KEYWORD_CHARS_DEF) begin
         sc_name[8*sc_len +: 8] = c;
      end
      if (sc_len != tlt_pkg::RUN_MAX) begin
         sc_len = sc_len + 8'd1;
      end
   endfunction

   function automatic void add_digit(input logic [7:0] c);
      logic [34:0] v;
      v = {4'b0, sc_acc} * 35'd10 + {27'b0, c - "0"};
      sc_acc = (v > {4'b0, tlt_pkg::NUMBER_MAX}) ? tlt_pkg::NUMBER_MAX : v[30:0];
      if (sc_len != tlt_pkg::RUN_MAX) begin
         sc_len = sc_len + 8'd1;
      end
   endfunction

   function automatic void close_token();
      int k;
      case (sc_mode)
         SCAN_NAME: begin
            k = find_keyword();
            if (k >= 0) begin
               push_token(tlt_pkg::KIND_KEYWORD, 4'(k), 31'd0, sc_len);
            end else begin
               push_token(tlt_pkg::KIND_IDENT, NO_CODE, 31'd0, sc_len);
            end
         end
         SCAN_NUM: begin
            push_token(tlt_pkg::KIND_NUMBER, NO_CODE, sc_acc, sc_len);
         end
         SCAN_OPER: begin
            case (sc_op)
               tlt_pkg::CH_EQUAL: push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_EQ, 31'd0, 8'd1);
               tlt_pkg::CH_LT:    push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_LT, 31'd0, 8'd1);
               tlt_pkg::CH_GT:    push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_GT, 31'd0, 8'd1);
               tlt_pkg::CH_PLUS:
                  push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_PLUS, 31'd0, 8'd1);
               tlt_pkg::CH_MINUS:
                  push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_MINUS, 31'd0, 8'd1);
               tlt_pkg::CH_STAR:
                  push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_TIMES, 31'd0, 8'd1);
               tlt_pkg::CH_SLASH:
                  push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_OVER, 31'd0, 8'd1);
               tlt_pkg::CH_SEMI:
                  push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_SEMI, 31'd0, 8'd1);
               default: push_token(tlt_pkg::KIND_ERROR, NO_CODE, 31'd0, 8'd1);
            endcase
         end
         default: ;
      endcase
      if (sc_mode != SCAN_COMMENT) begin
         clear_run();
      end
   endfunction

   function automatic void start_char(input logic [7:0] c);
      clear_run();
      if (c == tlt_pkg::CH_NEWLINE) begin
         bump_line();
      end else if (is_numeral(c)) begin
         sc_mode = SCAN_NUM;
         add_digit(c);
      end else if (is_letter(c)) begin
         sc_mode = SCAN_NAME;
         add_letter(c);
      end else if (c == tlt_pkg::CH_LBRACE) begin
         sc_mode = SCAN_COMMENT;
      end else if (c == tlt_pkg::CH_COLON || c == tlt_pkg::CH_GT || c == tlt_pkg::CH_LT ||
                   c == tlt_pkg::CH_EQUAL || c == tlt_pkg::CH_PLUS || c == tlt_pkg::CH_MINUS ||
                   c == tlt_pkg::CH_SEMI || c == tlt_pkg::CH_SLASH || c == tlt_pkg::CH_STAR)
      begin
         sc_mode = SCAN_OPER;
         sc_op   = c;
         sc_len  = 8'd1;
      end else if (c == tlt_pkg::CH_LPAREN) begin
         push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_LPAREN, 31'd0, 8'd1);
      end else if (c == tlt_pkg::CH_RPAREN) begin
         push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_RPAREN, 31'd0, 8'd1);
      end
   endfunction

   // expected tokens for one accepted source byte
   function automatic void scan_char(input logic [7:0] c, input logic eoi);
      int first;
      first = expected_tokens.size();
      if (eoi) begin
         close_token();
         push_token(tlt_pkg::KIND_END_OF_FILE, NO_CODE, 31'd0, 8'd0);
         scanner_reset();
      end else begin
         case (sc_mode)
            SCAN_NAME: begin
               if (is_letter(c)) begin
                  add_letter(c);
               end else begin
                  close_token();
                  start_char(c);
               end
            end
            SCAN_NUM: begin
               if (is_numeral(c)) begin
                  add_digit(c);
               end else begin
                  close_token();
                  start_char(c);
               end
            end
            SCAN_OPER: begin
               if (c == tlt_pkg::CH_EQUAL) begin
                  if (sc_op == tlt_pkg::CH_COLON) begin
                     push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_ASSIGN, 31'd0, 8'd2);
                  end else if (sc_op == tlt_pkg::CH_LT) begin
                     push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_LE, 31'd0, 8'd2);
                  end else if (sc_op == tlt_pkg::CH_GT) begin
                     push_token(tlt_pkg::KIND_OPER, tlt_pkg::OP_GE, 31'd0, 8'd2);
                  end else begin
                     push_token(tlt_pkg::KIND_ERROR, NO_CODE, 31'd0, 8'd2);
                  end
                  clear_run();
               end else begin
                  close_token();
                  start_char(c);
               end
            end
            SCAN_COMMENT: begin
               if (c == tlt_pkg::CH_RBRACE) begin
                  sc_mode = SCAN_START;
               end else if (c == tlt_pkg::CH_NEWLINE) begin
                  bump_line();
               end
            end
            default: start_char(c);
         endcase
      end
      if (expected_tokens.size() > first) begin
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("%0t token %0d: %s got %0d, expected %0d", $realtime, token_index, what,
                  got, want);
      end
   endtask

   task automatic check_token();
      tlt_pkg::token_type got;
      tlt_pkg::token_type want;
      got.kind   = rsp_chan.token_kind;
      got.code   = rsp_chan.token_code;
      got.value  = rsp_chan.number_value;
      got.length = rsp_chan.text_length;
      got.line   = rsp_chan.line_number;
      got.last   = rsp_chan.last_result;
      if (expected_tokens.size() == 0) begin
         report_mismatch("token with none outstanding, kind", got.kind, -1);
      end else begin
         want = expected_tokens.pop_front();
         if (got.kind != want.kind) report_mismatch("token_kind", got.kind, want.kind);
         if (got.code != want.code) report_mismatch("token_code", got.code, want.code);
         if (got.value != want.value) report_mismatch("number_value", got.value, want.value);
         if (got.length != want.length) report_mismatch("text_length", got.length, want.length);
         if (got.line != want.line) report_mismatch("line_number", got.line, want.line);
         if (got.last != want.last) report_mismatch("last_result", got.last, want.last);
      end
      token_index++;
   endtask

   // ---------------- source queue ----------------
   function automatic void add_char(input logic [7:0] c, input logic eoi = 1'b0);
      source_char_type s;
      s.ch        = c;
      s.eoi       = eoi;
      s.wait_idle = mark_pause;
      mark_pause  = 1'b0;
      source_chars.insert(source_chars.size(), s);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i]);
      end
   endfunction

   function automatic logic [7:0] any_letter();
      logic [7:0] c;
      c = 8'("a") + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 3) == 0) begin
         c = c - 8'h20;
      end
      return c;
   endfunction

   function automatic void add_letters(input int n);
      for (int i = 0; i < n; i++) begin
         add_char(any_letter());
      end
   endfunction

   function automatic void add_digits(input int n);
      for (int i = 0; i < n; i++) begin
         add_char(8'("0") + 8'($urandom_range(0, 9)));
      end
   endfunction

   // mostly program-like text with random content, some noise
   function automatic void fill_random(input int n);
      int start;
      logic [7:0] c;
      start = source_chars.size();
      mark_pause = 1'b1;
      while (source_chars.size() - start < n) begin
         if ($urandom_range(0, 149) == 0) begin
            mark_pause = 1'b1;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
               add_text(kw_names[$urandom_range(0, 7)]);
               if ($urandom_range(0, 5) == 0) add_letters($urandom_range(1, 2));
            end
            4, 5: begin
               if ($urandom_range(0, 29) == 0) add_letters($urandom_range(250, 300));
               else add_letters($urandom_range(1, 8));
            end
            6, 7, 8: begin
               case ($urandom_range(0, 29))
                  0:       add_digits($urandom_range(250, 270));
                  1, 2:    add_text(big_numbers[$urandom_range(0, 4)]);
                  default: add_digits($urandom_range(1, 12));
               endcase
            end
            9, 10, 11: add_text(op_texts[$urandom_range(0, 19)]);
            12: begin
               add_char(tlt_pkg::CH_LBRACE);
               repeat ($urandom_range(0, 12)) begin
                  case ($urandom_range(0, 3))
                     0: add_char(tlt_pkg::CH_NEWLINE);
                     1: add_char(any_letter());
                     default: begin
                        c = 8'($urandom_range(0, 255));
                        add_char(c == tlt_pkg::CH_RBRACE ? tlt_pkg::CH_LBRACE : c);
                     end
                  endcase
               end
               if ($urandom_range(0, 9) != 0) add_char(tlt_pkg::CH_RBRACE);
            end
            13: add_char(tlt_pkg::CH_NEWLINE);
            14: begin
               add_char(CH_CR);
               add_char(tlt_pkg::CH_NEWLINE);
            end
            15: add_char(8'($urandom_range(0, 255)));
            16: begin
               if ($urandom_range(0, 3) == 0) add_char(8'($urandom_range(0, 255)), 1'b1);
               else add_char(CH_SPACE);
            end
            default: add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         endcase
         case ($urandom_range(0, 5))
            0, 1:    add_char(CH_SPACE);
            2:       add_char(CH_TAB);
            3:       add_char(tlt_pkg::CH_NEWLINE);
            default: ;
         endcase
      end
      add_char(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            scan_char(in_flight.ch, in_flight.eoi);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (source_chars.size() != 0 &&
                !(source_chars[0].wait_idle && expected_tokens.size() != 0) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               in_flight = source_chars.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.char_code    <= in_flight.ch;
               req_chan.end_of_input <= in_flight.eoi;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_token();
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (run_phase != rx_phase) begin
            rx_phase = run_phase;
            if (run_phase == PH_FREE) begin
               hold_left = LONG_HOLD;
            end
            rsp_chan.ready <= (run_phase != PH_FREE);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic run_phase_to_idle(input run_phase_type ph, input int send_pct,
                                    input int recv_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      run_phase      = ph;
      case (ph)
         PH_DIRECTED: begin
            add_text("if:=0<=a>=Z=+=;:(9)");
            add_char(CH_TAB);
            add_char(tlt_pkg::CH_LBRACE);
            add_char(tlt_pkg::CH_NEWLINE);
            add_char(tlt_pkg::CH_RBRACE);
            add_char(CH_CR);
            add_char(CH_HIGH);
            add_text("-*/>");
            add_char(CH_HIGH, 1'b1);
         end
         PH_LINES: begin
            // line count advances in plain text and inside a comment
            mark_pause = 1'b1;
            repeat (12) add_char(tlt_pkg::CH_NEWLINE);
            add_char(tlt_pkg::CH_LBRACE);
            repeat (9) add_char(tlt_pkg::CH_NEWLINE);
            add_char(tlt_pkg::CH_RBRACE);
            add_text("x");
            add_char(tlt_pkg::CH_NEWLINE);
            add_text("7");
            add_char(tlt_pkg::CH_LBRACE);
            add_char(8'h00, 1'b1);
         end
         default: fill_random(RANDOM_CHARS);
      endcase
      while (source_chars.size() != 0 || req_chan.valid || expected_tokens.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.char_code    = 8'h00;
      req_chan.end_of_input = 1'b0;
      rsp_chan.ready        = 1'b0;
      scanner_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_phase_to_idle(PH_DIRECTED, 0, 0);
      run_phase_to_idle(PH_LINES, 0, 0);
      run_phase_to_idle(PH_FREE, 0, 0);
      run_phase_to_idle(PH_SEND_IDLE, 58, 0);
      run_phase_to_idle(PH_RECV_STALL, 0, 58);
      run_phase_to_idle(PH_BOTH, 37, 37);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
